// ===== src/ppm_p6_stream_decoder_assert.svh =====
// Assertion macros used by the decoder checker.
`ifndef PPM_P6_STREAM_DECODER_ASSERT_SVH
`define PPM_P6_STREAM_DECODER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define PPMDEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define PPMDEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ppmdec_pkg.sv =====
// Types, constants and helper functions for the PPM P6 stream decoder.
`default_nettype none

package ppmdec_pkg;

  localparam int DIM_BITS  = 16;
  localparam int TOK_BITS  = DIM_BITS + 1;
  localparam int DATA_W    = 8;
  localparam int PIXEL_W   = 24;
  localparam int IMG_DIM_W = 16;
  localparam int KIND_W    = 2;
  localparam int ERR_W     = 3;

  localparam logic [TOK_BITS-1:0] TOK_MAX = {TOK_BITS{1'b1}};
  localparam logic [TOK_BITS-1:0] DIM_MAX = {1'b0, {DIM_BITS{1'b1}}};
  localparam logic [TOK_BITS-1:0] MAXVAL  = TOK_BITS'(255);

  localparam logic [DATA_W-1:0] CHR_P     = 8'h50;
  localparam logic [DATA_W-1:0] CHR_6     = 8'h36;
  localparam logic [DATA_W-1:0] CHR_HASH  = 8'h23;
  localparam logic [DATA_W-1:0] CHR_LF    = 8'h0A;
  localparam logic [DATA_W-1:0] CHR_CR    = 8'h0D;
  localparam logic [DATA_W-1:0] CHR_TAB   = 8'h09;
  localparam logic [DATA_W-1:0] CHR_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CHR_ZERO  = 8'h30;
  localparam logic [DATA_W-1:0] CHR_NINE  = 8'h39;

  localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

  localparam logic [ERR_W-1:0] ERR_BAD_MAGIC  = 3'd0;
  localparam logic [ERR_W-1:0] ERR_MISSING    = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_WIDTH  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_HEIGHT = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BAD_MAXVAL = 3'd4;
  localparam logic [ERR_W-1:0] ERR_TRUNCATED  = 3'd5;

  typedef enum logic [2:0] {
    PH_P,
    PH_6,
    PH_TAIL,
    PH_W,
    PH_H,
    PH_M,
    PH_PIX,
    PH_STOP
  } phase_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [PIXEL_W-1:0]   pixel;
    logic [IMG_DIM_W-1:0] image_width;
    logic [IMG_DIM_W-1:0] image_height;
    logic [ERR_W-1:0]     error_code;
    logic                 last_pixel;
  } result_t;

  function automatic logic is_ws(input logic [DATA_W-1:0] b);
    return (b == CHR_SPACE) || ((b >= CHR_TAB) && (b <= CHR_CR));
  endfunction

  function automatic logic is_digit(input logic [DATA_W-1:0] b);
    return (b >= CHR_ZERO) && (b <= CHR_NINE);
  endfunction

endpackage

`default_nettype wire

// ===== src/ppmdec_if.sv =====
// Stream and configuration channel interfaces of the decoder.
`default_nettype none

interface ppmdec_byte_if;
  logic                            valid;
  logic                            ready;
  logic [ppmdec_pkg::DATA_W-1:0]   data_byte;
  logic                            end_of_stream;
  modport source(output valid, data_byte, end_of_stream, input ready);
  modport sink(input valid, data_byte, end_of_stream, output ready);
endinterface

interface ppmdec_result_if;
  logic                             valid;
  logic                             ready;
  logic [ppmdec_pkg::KIND_W-1:0]    kind;
  logic [ppmdec_pkg::PIXEL_W-1:0]   pixel;
  logic [ppmdec_pkg::IMG_DIM_W-1:0] image_width;
  logic [ppmdec_pkg::IMG_DIM_W-1:0] image_height;
  logic [ppmdec_pkg::ERR_W-1:0]     error_code;
  logic                             last_pixel;
  modport source(output valid, kind, pixel, image_width, image_height, error_code,
                 last_pixel, input ready);
  modport sink(input valid, kind, pixel, image_width, image_height, error_code,
               last_pixel, output ready);
endinterface

interface ppmdec_cfg_if;
  logic valid;
  logic ready;
  logic color_order;
  modport source(output valid, color_order, input ready);
  modport sink(input valid, color_order, output ready);
endinterface

`default_nettype wire

// ===== src/ppmdec_parser.sv =====
// Parser state machine: one byte per transfer, at most one result per byte.
`default_nettype none

module ppmdec_parser (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            step,
  input  wire logic [ppmdec_pkg::DATA_W-1:0]   data_byte,
  input  wire logic                            end_of_stream,
  input  wire logic                            color_order,
  output      logic                            res_valid,
  output      ppmdec_pkg::result_t             res
);

  ppmdec_pkg::phase_t phase, phase_next;
  logic                              in_comment, comment_next;
  logic [ppmdec_pkg::TOK_BITS-1:0]   tok_value, tok_next;
  logic                              tok_started, started_next;
  logic                              tok_frozen, frozen_next;
  logic [ppmdec_pkg::DIM_BITS-1:0]   width_reg, width_next;
  logic [ppmdec_pkg::DIM_BITS-1:0]   height_reg, height_next;
  logic [ppmdec_pkg::DIM_BITS-1:0]   col, col_next;
  logic [ppmdec_pkg::DIM_BITS-1:0]   row, row_next;
  logic [1:0]                        byte_slot, slot_next;
  logic [15:0]                       held_bytes, held_next;

  logic                              sep;
  logic                              skip;
  logic                              fail;
  logic [ppmdec_pkg::ERR_W-1:0]      fail_code;
  logic [ppmdec_pkg::ERR_W-1:0]      phase_err;
  logic                              area_zero;
  logic                              col_end;
  logic                              row_end;
  logic [ppmdec_pkg::TOK_BITS+3:0]   tok_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ppmdec_pkg::PH_P;
      in_comment  <= 1'b0;
      tok_value   <= '0;
      tok_started <= 1'b0;
      tok_frozen  <= 1'b0;
      width_reg   <= '0;
      height_reg  <= '0;
      col         <= '0;
      row         <= '0;
      byte_slot   <= '0;
      held_bytes  <= '0;
    end else begin
      phase       <= phase_next;
      in_comment  <= comment_next;
      tok_value   <= tok_next;
      tok_started <= started_next;
      tok_frozen  <= frozen_next;
      width_reg   <= width_next;
      height_reg  <= height_next;
      col         <= col_next;
      row         <= row_next;
      byte_slot   <= slot_next;
      held_bytes  <= held_next;
    end
  end

  assign area_zero = (width_reg == '0) || (height_reg == '0);
  assign col_end   = (col == width_reg - ppmdec_pkg::DIM_BITS'(1));
  assign row_end   = (row == height_reg - ppmdec_pkg::DIM_BITS'(1));
  assign tok_sum   = {1'b0, tok_value, 3'b000} + {3'b000, tok_value, 1'b0}
                   + {{(ppmdec_pkg::TOK_BITS){1'b0}}, data_byte[3:0]};

  always_comb begin
    case (phase)
      ppmdec_pkg::PH_W: phase_err = ppmdec_pkg::ERR_BAD_WIDTH;
      ppmdec_pkg::PH_H: phase_err = ppmdec_pkg::ERR_BAD_HEIGHT;
      default:          phase_err = ppmdec_pkg::ERR_BAD_MAXVAL;
    endcase
  end

  always_comb begin
    phase_next   = phase;
    comment_next = in_comment;
    tok_next     = tok_value;
    started_next = tok_started;
    frozen_next  = tok_frozen;
    width_next   = width_reg;
    height_next  = height_reg;
    col_next     = col;
    row_next     = row;
    slot_next    = byte_slot;
    held_next    = held_bytes;
    res_valid    = 1'b0;
    res          = '0;
    sep          = 1'b0;
    skip         = 1'b0;
    fail         = 1'b0;
    fail_code    = ppmdec_pkg::ERR_BAD_MAGIC;

    if (step && end_of_stream) begin
      case (phase)
        ppmdec_pkg::PH_P, ppmdec_pkg::PH_6: begin
          res_valid      = 1'b1;
          res.kind       = ppmdec_pkg::KIND_ERROR;
          res.error_code = ppmdec_pkg::ERR_BAD_MAGIC;
        end
        ppmdec_pkg::PH_TAIL, ppmdec_pkg::PH_W, ppmdec_pkg::PH_H: begin
          res_valid      = 1'b1;
          res.kind       = ppmdec_pkg::KIND_ERROR;
          res.error_code = ppmdec_pkg::ERR_MISSING;
        end
        ppmdec_pkg::PH_M: begin
          res_valid = 1'b1;
          res.kind  = ppmdec_pkg::KIND_ERROR;
          if (!tok_started) begin
            res.error_code = ppmdec_pkg::ERR_MISSING;
          end else if (tok_value != ppmdec_pkg::MAXVAL) begin
            res.error_code = ppmdec_pkg::ERR_BAD_MAXVAL;
          end else if (area_zero) begin
            res.kind         = ppmdec_pkg::KIND_HEADER;
            res.image_width  = ppmdec_pkg::IMG_DIM_W'(width_reg);
            res.image_height = ppmdec_pkg::IMG_DIM_W'(height_reg);
          end else begin
            res.error_code = ppmdec_pkg::ERR_TRUNCATED;
          end
        end
        ppmdec_pkg::PH_PIX: begin
          res_valid      = 1'b1;
          res.kind       = ppmdec_pkg::KIND_ERROR;
          res.error_code = ppmdec_pkg::ERR_TRUNCATED;
        end
        default: ;
      endcase
      phase_next   = ppmdec_pkg::PH_P;
      comment_next = 1'b0;
      tok_next     = '0;
      started_next = 1'b0;
      frozen_next  = 1'b0;
      width_next   = '0;
      height_next  = '0;
      col_next     = '0;
      row_next     = '0;
      slot_next    = '0;
      held_next    = '0;
    end else if (step) begin
      case (phase)
        ppmdec_pkg::PH_P: begin
          if (data_byte != ppmdec_pkg::CHR_P) begin
            fail = 1'b1;
          end else begin
            phase_next = ppmdec_pkg::PH_6;
          end
        end
        ppmdec_pkg::PH_6: begin
          if (data_byte != ppmdec_pkg::CHR_6) begin
            fail = 1'b1;
          end else begin
            phase_next = ppmdec_pkg::PH_TAIL;
          end
        end
        ppmdec_pkg::PH_TAIL: begin
          if (ppmdec_pkg::is_ws(data_byte)) begin
            phase_next = ppmdec_pkg::PH_W;
          end else if (data_byte == ppmdec_pkg::CHR_HASH) begin
            comment_next = 1'b1;
            phase_next   = ppmdec_pkg::PH_W;
          end
        end
        ppmdec_pkg::PH_W, ppmdec_pkg::PH_H, ppmdec_pkg::PH_M: begin
          if (in_comment) begin
            if (data_byte == ppmdec_pkg::CHR_LF || data_byte == ppmdec_pkg::CHR_CR) begin
              comment_next = 1'b0;
              sep          = 1'b1;
            end else begin
              skip = 1'b1;
            end
          end else if (data_byte == ppmdec_pkg::CHR_HASH) begin
            comment_next = 1'b1;
            skip         = 1'b1;
          end else if (ppmdec_pkg::is_ws(data_byte)) begin
            sep = 1'b1;
          end
          if (skip) begin
          end else if (sep) begin
            if (tok_started) begin
              if (phase == ppmdec_pkg::PH_W) begin
                if (tok_value > ppmdec_pkg::DIM_MAX) begin
                  fail      = 1'b1;
                  fail_code = ppmdec_pkg::ERR_BAD_WIDTH;
                end else begin
                  width_next   = ppmdec_pkg::DIM_BITS'(tok_value);
                  phase_next   = ppmdec_pkg::PH_H;
                  tok_next     = '0;
                  started_next = 1'b0;
                  frozen_next  = 1'b0;
                end
              end else if (phase == ppmdec_pkg::PH_H) begin
                if (tok_value > ppmdec_pkg::DIM_MAX) begin
                  fail      = 1'b1;
                  fail_code = ppmdec_pkg::ERR_BAD_HEIGHT;
                end else begin
                  height_next  = ppmdec_pkg::DIM_BITS'(tok_value);
                  phase_next   = ppmdec_pkg::PH_M;
                  tok_next     = '0;
                  started_next = 1'b0;
                  frozen_next  = 1'b0;
                end
              end else if (tok_value != ppmdec_pkg::MAXVAL) begin
                fail      = 1'b1;
                fail_code = ppmdec_pkg::ERR_BAD_MAXVAL;
              end else begin
                res_valid        = 1'b1;
                res.kind         = ppmdec_pkg::KIND_HEADER;
                res.image_width  = ppmdec_pkg::IMG_DIM_W'(width_reg);
                res.image_height = ppmdec_pkg::IMG_DIM_W'(height_reg);
                phase_next       = area_zero ? ppmdec_pkg::PH_STOP : ppmdec_pkg::PH_PIX;
                col_next         = '0;
                row_next         = '0;
                slot_next        = '0;
                held_next        = '0;
                tok_next         = '0;
                started_next     = 1'b0;
                frozen_next      = 1'b0;
              end
            end
          end else if (!tok_started) begin
            started_next = 1'b1;
            if (!ppmdec_pkg::is_digit(data_byte)) begin
              fail      = 1'b1;
              fail_code = phase_err;
            end else begin
              tok_next = ppmdec_pkg::TOK_BITS'(data_byte[3:0]);
            end
          end else if (!tok_frozen) begin
            if (ppmdec_pkg::is_digit(data_byte)) begin
              if (tok_sum > {4'b0000, ppmdec_pkg::TOK_MAX}) begin
                tok_next = ppmdec_pkg::TOK_MAX;
              end else begin
                tok_next = ppmdec_pkg::TOK_BITS'(tok_sum);
              end
            end else begin
              frozen_next = 1'b1;
            end
          end
        end
        ppmdec_pkg::PH_PIX: begin
          if (byte_slot != 2'd2) begin
            held_next = {held_bytes[7:0], data_byte};
            slot_next = byte_slot + 2'd1;
          end else begin
            res_valid = 1'b1;
            res.kind  = ppmdec_pkg::KIND_PIXEL;
            if (color_order) begin
              res.pixel = {data_byte, held_bytes[7:0], held_bytes[15:8]};
            end else begin
              res.pixel = {held_bytes, data_byte};
            end
            res.last_pixel = col_end && row_end;
            slot_next      = '0;
            held_next      = '0;
            if (col_end) begin
              col_next = '0;
              row_next = row + ppmdec_pkg::DIM_BITS'(1);
            end else begin
              col_next = col + ppmdec_pkg::DIM_BITS'(1);
            end
            if (col_end && row_end) begin
              phase_next = ppmdec_pkg::PH_STOP;
            end
          end
        end
        default: ;
      endcase
      if (fail) begin
        phase_next     = ppmdec_pkg::PH_STOP;
        comment_next   = 1'b0;
        res_valid      = 1'b1;
        res            = '0;
        res.kind       = ppmdec_pkg::KIND_ERROR;
        res.error_code = fail_code;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ppmdec_out_reg.sv =====
// Result register with a skid stage toward the result channel.
`default_nettype none

module ppmdec_out_reg (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  res_valid,
  input  wire ppmdec_pkg::result_t   res,
  output      logic                  space,
  ppmdec_result_if.source            result_out
);

  logic                out_valid;
  ppmdec_pkg::result_t out_data;
  logic                skid_valid;
  ppmdec_pkg::result_t skid_data;
  logic                load;
  logic                drain;

  assign space = !skid_valid;
  assign load  = space && res_valid;
  assign drain = !out_valid || result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= load;
      end
    end else if (load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (load) begin
        out_data <= res;
      end
    end else if (load) begin
      skid_data <= res;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.kind         = out_data.kind;
  assign result_out.pixel        = out_data.pixel;
  assign result_out.image_width  = out_data.image_width;
  assign result_out.image_height = out_data.image_height;
  assign result_out.error_code   = out_data.error_code;
  assign result_out.last_pixel   = out_data.last_pixel;

endmodule

`default_nettype wire

// ===== src/ppm_p6_stream_decoder.sv =====
// PPM P6 stream decoder top level: byte channel in, result channel out.
// Each result is registered in ppmdec_out_reg before it appears on result_out.
// Throughput: one byte per cycle while the skid stage is empty; a two-entry result
// register and skid stage keep byte_in ready while one result waits on result_out.
// Reset (rst, synchronous) returns the parser to expect the magic and
// clears color_order; an end_of_stream item restarts the parser only.
`default_nettype none

module ppm_p6_stream_decoder (
  input  wire logic         clk,
  input  wire logic         rst,
  ppmdec_byte_if.sink       byte_in,
  ppmdec_cfg_if.sink        cfg,
  ppmdec_result_if.source   result_out
);

  logic                color_order;
  logic                space;
  logic                step;
  logic                res_valid;
  ppmdec_pkg::result_t res;

  assign cfg.ready     = 1'b1;
  assign byte_in.ready = space;
  assign step          = byte_in.valid && space;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_order <= 1'b0;
    end else if (cfg.valid) begin
      color_order <= cfg.color_order;
    end
  end

  ppmdec_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .data_byte     (byte_in.data_byte),
    .end_of_stream (byte_in.end_of_stream),
    .color_order   (color_order),
    .res_valid     (res_valid),
    .res           (res)
  );

  ppmdec_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res        (res),
    .space      (space),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

// ===== src/ppmdec_checker.sv =====
// Port-level checker for the decoder result channel, bound to the top level.
`default_nettype none

`include "ppm_p6_stream_decoder_assert.svh"

module ppmdec_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [ppmdec_pkg::KIND_W-1:0]    kind,
  input wire logic [ppmdec_pkg::PIXEL_W-1:0]   pixel,
  input wire logic [ppmdec_pkg::IMG_DIM_W-1:0] image_width,
  input wire logic [ppmdec_pkg::IMG_DIM_W-1:0] image_height,
  input wire logic [ppmdec_pkg::ERR_W-1:0]     error_code,
  input wire logic                             last_pixel
);

  `PPMDEC_ASSERT_NOW(a_pixel_fields, out_valid && kind == ppmdec_pkg::KIND_PIXEL, error_code == ppmdec_pkg::ERR_BAD_MAGIC && image_width == '0 && image_height == '0, "pixel result carries header or error fields")
  `PPMDEC_ASSERT_NOW(a_header_fields, out_valid && kind == ppmdec_pkg::KIND_HEADER, pixel == '0 && last_pixel == 1'b0 && error_code == ppmdec_pkg::ERR_BAD_MAGIC, "header result carries pixel or error fields")
  `PPMDEC_ASSERT_NOW(a_error_fields, out_valid && kind == ppmdec_pkg::KIND_ERROR, error_code <= ppmdec_pkg::ERR_TRUNCATED && pixel == '0 && last_pixel == 1'b0, "error result out of range or carries pixel")
  `PPMDEC_ASSERT_NEXT(a_hold_result, out_valid && !out_ready, out_valid && $stable(kind) && $stable(pixel) && $stable(error_code), "stalled result changed")

endmodule

bind ppm_p6_stream_decoder ppmdec_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .kind         (result_out.kind),
  .pixel        (result_out.pixel),
  .image_width  (result_out.image_width),
  .image_height (result_out.image_height),
  .error_code   (result_out.error_code),
  .last_pixel   (result_out.last_pixel)
);

`default_nettype wire
